@@ src/iirdf2_pkg.sv @@
// ----------------------------------------------------------------------------
// iirdf2_pkg: shared types and constants of the direct form II IIR filter
// Widths of samples, coefficients, delay entries and accumulators, register
// indexes and the control bundles that pass between the filter's modules.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

  // Filter order: number of delay entries and of tap cells.
  localparam int ORDER = 3;

  // Field widths.
  localparam int DATA_W = 16;
  localparam int COEF_W = 18;
  localparam int DLY_W  = 24;

  // Product of a coefficient and a delay entry, and the accumulator width.
  localparam int PROD_W = COEF_W + DLY_W;
  localparam int ACC_W  = 48;

  // Fixed-point scaling: sample enters at Q22, w leaves at Q8, y at Q0.
  localparam int X_SHIFT = 22;
  localparam int W_SHIFT = 14;
  localparam int Y_SHIFT = 22;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W    = 3;
  localparam int REG_FF0      = 0;
  localparam int REG_FB_FIRST = 4;
  // Highest tap that has a coefficient register.
  localparam int NUM_COEF_TAPS = 3;

  // Tap step counter: two multiplies per tap.
  localparam int STEP_W = (2 * ORDER > 1) ? $clog2(2 * ORDER) : 1;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DLY_W-1:0]  dly_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Saturation bounds in accumulator width.
  localparam acc_t W_HI = ACC_W'(2 ** (DLY_W - 1) - 1);
  localparam acc_t W_LO = ~W_HI;
  localparam acc_t Y_HI = ACC_W'(2 ** (DATA_W - 1) - 1);
  localparam acc_t Y_LO = ~Y_HI;

  // Control of the tap cells, shared by every cell.
  typedef struct packed {
    logic rot_en;    // rotate delay and coefficients one cell along
    logic shift_en;  // shift a new w in, coefficients stay
  } cell_ctrl_t;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic load;      // start a new sample: seed the accumulators
    logic mul_en;    // take a product this cycle
    logic neg;       // product belongs to the feedback sum
  } mac_ctrl_t;

endpackage

@@ src/iirdf2_cell.sv @@
// ----------------------------------------------------------------------------
// iirdf2_cell: one tap cell of the filter
// Holds one delay entry and the feedback and feedforward coefficients of its
// tap. The cells form a ring that rotates during the tap sums and a shift
// line that takes the new w at the end of each sample.
// ----------------------------------------------------------------------------
module iirdf2_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iirdf2_pkg::cell_ctrl_t ctrl,
  input  logic                   ff_we,
  input  logic                   fb_we,
  input  iirdf2_pkg::coef_t      cfg_coef,
  input  iirdf2_pkg::dly_t       d_in,
  input  iirdf2_pkg::coef_t      a_in,
  input  iirdf2_pkg::coef_t      b_in,
  output iirdf2_pkg::dly_t       d_out,
  output iirdf2_pkg::coef_t      a_out,
  output iirdf2_pkg::coef_t      b_out
);
  import iirdf2_pkg::*;

  dly_t  d_r;
  coef_t a_r;
  coef_t b_r;

  // Delay entry: moves on rotation and on shift-in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (ctrl.rot_en || ctrl.shift_en) begin
      d_r <= d_in;
    end
  end

  // Coefficients: written by configuration, move only on rotation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else if (ctrl.rot_en) begin
      a_r <= a_in;
      b_r <= b_in;
    end else begin
      if (fb_we) begin
        a_r <= cfg_coef;
      end
      if (ff_we) begin
        b_r <= cfg_coef;
      end
    end
  end

  assign d_out = d_r;
  assign a_out = a_r;
  assign b_out = b_r;

endmodule

@@ src/iirdf2_mac.sv @@
// ----------------------------------------------------------------------------
// iirdf2_mac: shared multiply-accumulate unit
// One registered multiplier feeding a feedback and a feedforward accumulator,
// with rounding and saturation of w and of the output sample.
// ----------------------------------------------------------------------------
module iirdf2_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iirdf2_pkg::mac_ctrl_t ctrl,
  input  iirdf2_pkg::sample_t   x,
  input  iirdf2_pkg::coef_t     coef,
  input  iirdf2_pkg::dly_t      data,
  output iirdf2_pkg::dly_t      w_sat,
  output iirdf2_pkg::sample_t   y_sat
);
  import iirdf2_pkg::*;

  prod_t prod_c;
  prod_t prod_r;
  logic  pv_r;
  logic  neg_r;
  acc_t  facc_r;
  acc_t  yacc_r;
  acc_t  f_rnd;
  acc_t  f_q;
  acc_t  y_rnd;
  acc_t  y_q;

  // Multiplier stage.
  assign prod_c = coef * data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      neg_r <= 1'b0;
    end else begin
      pv_r  <= ctrl.mul_en;
      neg_r <= ctrl.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_c;
    end
  end

  // Accumulators: feedback subtracts, feedforward adds.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      facc_r <= ACC_W'(x) <<< X_SHIFT;
      yacc_r <= '0;
    end else if (pv_r) begin
      if (neg_r) begin
        facc_r <= facc_r - ACC_W'(prod_r);
      end else begin
        yacc_r <= yacc_r + ACC_W'(prod_r);
      end
    end
  end

  // Round half up and saturate w to the delay width.
  assign f_rnd = facc_r + (ACC_W'(1) <<< (W_SHIFT - 1));
  assign f_q   = f_rnd >>> W_SHIFT;

  always_comb begin
    if (f_q > W_HI) begin
      w_sat = W_HI[DLY_W-1:0];
    end else if (f_q < W_LO) begin
      w_sat = W_LO[DLY_W-1:0];
    end else begin
      w_sat = f_q[DLY_W-1:0];
    end
  end

  // Round half up and saturate the output sample.
  assign y_rnd = yacc_r + (ACC_W'(1) <<< (Y_SHIFT - 1));
  assign y_q   = y_rnd >>> Y_SHIFT;

  always_comb begin
    if (y_q > Y_HI) begin
      y_sat = Y_HI[DATA_W-1:0];
    end else if (y_q < Y_LO) begin
      y_sat = Y_LO[DATA_W-1:0];
    end else begin
      y_sat = y_q[DATA_W-1:0];
    end
  end

endmodule

@@ src/iir_direct_form_two_top.sv @@
// ----------------------------------------------------------------------------
// iir_direct_form_two_top: direct form II IIR filter, order ORDER
// A ring of tap cells rotates its delay entries and coefficients past one
// shared multiply-accumulate unit, then shifts the new w into the delay line.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on in_valid / in_stall / in_sample_in; a transfer
//   happens at a clock edge with in_valid high and in_stall low. Filtered
//   samples leave on out_valid / out_stall / out_sample_out in the same way.
//   Coefficients are written through cfg_we / cfg_index / cfg_data while the
//   filter is idle; index 0..3 are b0..b3, index 4..6 are a1..a3, other
//   indexes are ignored.
//   Each sample runs through the tap ring (one multiply per cycle, feedback
//   then feedforward of each tap); then S_WSAT rounds w, S_YMUL and S_YADD
//   form and add the b0 product, and S_FIN registers the rounded output and
//   waits while a result is still stalled. in_stall is high outside S_IDLE,
//   so a new sample is taken only once the last one has left the sequencer.
//   The output register holds one finished sample, so the next input is
//   taken while it waits; a further result waits until it is taken.
//   While out_stall is high the output holds.
//   Synchronous reset clears the delay line, sets b0 to one and the other
//   coefficients to zero, and empties the output.
// ----------------------------------------------------------------------------
module iir_direct_form_two_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  iirdf2_pkg::sample_t   in_sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iirdf2_pkg::sample_t   out_sample_out,
  input  logic                  cfg_we,
  input  iirdf2_pkg::cfg_idx_t  cfg_index,
  input  iirdf2_pkg::coef_t     cfg_data
);
  import iirdf2_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_WSAT = 3'd2;
  localparam logic [2:0] S_YMUL = 3'd3;
  localparam logic [2:0] S_YADD = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  sample_t           x_r;
  dly_t              w_r;
  coef_t             ff0_r;
  logic              out_valid_r;
  sample_t           out_sample_r;

  logic       in_xfer;
  logic       out_xfer;
  logic       out_free;
  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;
  coef_t      mul_coef;
  dly_t       mul_data;
  dly_t       w_sat;
  sample_t    y_sat;

  dly_t  d_out [ORDER];
  coef_t a_out [ORDER];
  coef_t b_out [ORDER];

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MAC;
          step_nxt  = '0;
        end
      end
      S_MAC: begin
        if (step_r == STEP_W'(2 * ORDER - 1)) begin
          state_nxt = S_WSAT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_WSAT: state_nxt = S_YMUL;
      S_YMUL: state_nxt = S_YADD;
      S_YADD: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Sample capture and rounded w.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= in_sample_in;
    end
    if (state_r == S_WSAT) begin
      w_r <= w_sat;
    end
  end

  // Coefficient b0 lives here; the tap cells hold the others.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0_r <= COEF_W'(1 <<< W_SHIFT);
    end else if (cfg_we && cfg_index == CFG_IDX_W'(REG_FF0)) begin
      ff0_r <= cfg_data;
    end
  end

  // Control of the ring and of the multiply-accumulate unit. The accumulators
  // are seeded in the first tap step, once the captured sample is stable.
  assign cell_ctrl.rot_en   = (state_r == S_MAC) && step_r[0];
  assign cell_ctrl.shift_en = (state_r == S_YMUL);
  assign mac_ctrl.load      = (state_r == S_MAC) && (step_r == '0);
  assign mac_ctrl.mul_en    = (state_r == S_MAC) || (state_r == S_YMUL);
  assign mac_ctrl.neg       = (state_r == S_MAC) && !step_r[0];

  // Multiplier operands: the tap of the last cell in the ring, or b0 and w.
  always_comb begin
    if (state_r == S_YMUL) begin
      mul_coef = ff0_r;
      mul_data = w_r;
    end else begin
      mul_coef = step_r[0] ? b_out[ORDER-1] : a_out[ORDER-1];
      mul_data = d_out[ORDER-1];
    end
  end

  // Ring of tap cells; cell i holds delay entry i and tap i+1's coefficients.
  for (genvar i = 0; i < ORDER; i++) begin : g_cell
    logic  ff_we;
    logic  fb_we;
    dly_t  d_in;
    coef_t a_in;
    coef_t b_in;

    if (i + 1 <= NUM_COEF_TAPS) begin : g_we
      assign ff_we = cfg_we && (cfg_index == CFG_IDX_W'(REG_FF0 + i + 1));
      assign fb_we = cfg_we && (cfg_index == CFG_IDX_W'(REG_FB_FIRST + i));
    end else begin : g_no_we
      assign ff_we = 1'b0;
      assign fb_we = 1'b0;
    end

    if (i == 0) begin : g_head
      assign d_in = cell_ctrl.shift_en ? w_r : d_out[ORDER-1];
      assign a_in = a_out[ORDER-1];
      assign b_in = b_out[ORDER-1];
    end else begin : g_body
      assign d_in = d_out[i-1];
      assign a_in = a_out[i-1];
      assign b_in = b_out[i-1];
    end

    iirdf2_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .ff_we    (ff_we),
      .fb_we    (fb_we),
      .cfg_coef (cfg_data),
      .d_in     (d_in),
      .a_in     (a_in),
      .b_in     (b_in),
      .d_out    (d_out[i]),
      .a_out    (a_out[i]),
      .b_out    (b_out[i])
    );
  end

  iirdf2_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .x     (x_r),
    .coef  (mul_coef),
    .data  (mul_data),
    .w_sat (w_sat),
    .y_sat (y_sat)
  );

  // Output register: holds one result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_sample_r <= y_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // An input transfer always starts the tap sums.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MAC) && (step_r == '0))
    else $error("tap sums did not start after input transfer");

  // A new result shows up only as the sequencer finishes a sample.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("output became valid outside the final step");

  // The step counter is back at zero whenever the ring is at rest.
  a_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MAC) |-> (step_r == '0))
    else $error("step counter not cleared outside the tap sums");

  // The final step never overwrites a result that is still stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_sample_r))
    else $error("stalled result was overwritten");

endmodule

@@ tb/tb_iir_direct_form_two_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iir_direct_form_two_top: self-checking testbench of the IIR filter
// Sends signed samples through the filter under random input gaps and output
// stalls. A bit-exact fixed-point predictor keeps its own delay line and
// coefficients, and every output transfer is compared with the oldest
// prediction. Coefficients change between phases while the filter is idle.
// ----------------------------------------------------------------------------
module tb_iir_direct_form_two_top;
  import iirdf2_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 32;
  localparam int SETTLE_CYCLES = 2 * ORDER + 10;
  localparam int TIMEOUT_NS    = 2000000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 185;
  localparam int CALM_PHASE    = 4;

  // Register map: b0..b3, then a1..a3; the last index has no register.
  localparam int       NUM_REGS   = REG_FB_FIRST + NUM_COEF_TAPS;
  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(NUM_REGS);

  localparam coef_t COEF_MAX = coef_t'(131071);
  localparam coef_t COEF_MIN = coef_t'(-131072);
  localparam coef_t COEF_ONE = coef_t'(16384);

  localparam longint W_MAX = (longint'(1) <<< (DLY_W - 1)) - 1;
  localparam longint W_MIN = -(longint'(1) <<< (DLY_W - 1));
  localparam longint Y_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) <<< (DATA_W - 1));

  typedef enum int { COEF_FULL, COEF_MILD, COEF_EXTREME } coef_mode_t;
  typedef enum int { SAMP_FULL, SAMP_SMALL, SAMP_EDGE } samp_mode_t;

  logic     clk          = 1'b0;
  logic     rst_n        = 1'b0;
  logic     in_valid     = 1'b0;
  logic     in_stall;
  sample_t  in_sample_in = '0;
  logic     out_valid;
  logic     out_stall    = 1'b0;
  sample_t  out_sample_out;
  logic     cfg_we       = 1'b0;
  cfg_idx_t cfg_index    = '0;
  coef_t    cfg_data     = '0;

  // Predictor state: coefficients as the filter holds them, and its delay line.
  coef_t ff_coef [0:ORDER];
  coef_t fb_coef [0:ORDER];
  dly_t  delay_w [0:ORDER-1];

  sample_t pending_samples [$];
  sample_t expected_samples [$];
  int      queued_count   = 0;
  int      accepted_count = 0;
  int      error_count    = 0;
  bit      calm           = 1'b0;
  bit      in_fired       = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  iir_direct_form_two_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Coefficients and delay line as they stand after reset.
  function automatic void reset_filter_model();
    for (int k = 0; k <= ORDER; k++) begin
      ff_coef[k] = '0;
      fb_coef[k] = '0;
    end
    for (int k = 0; k < ORDER; k++) begin
      delay_w[k] = '0;
    end
    ff_coef[0] = COEF_ONE;
  endfunction

  // Taps above the order and indexes without a register are dropped.
  function automatic void write_coef_model(input cfg_idx_t idx, input coef_t val);
    int i;
    int tap;
    i = int'(idx);
    if (i < REG_FB_FIRST) begin
      if (i <= ORDER) ff_coef[i] = val;
    end else if (i < NUM_REGS) begin
      tap = i - REG_FB_FIRST + 1;
      if (tap <= ORDER) fb_coef[tap] = val;
    end
  endfunction

  // One sample through the direct form II recursion, rounding half up.
  function automatic sample_t filter_step(input sample_t x);
    longint fb_acc;
    longint ff_acc;
    longint w;
    longint y;
    fb_acc = longint'(x) * (longint'(1) <<< X_SHIFT);
    ff_acc = 0;
    for (int k = 1; k <= ORDER; k++) begin
      fb_acc -= longint'(fb_coef[k]) * longint'(delay_w[k-1]);
      ff_acc += longint'(ff_coef[k]) * longint'(delay_w[k-1]);
    end
    w = (fb_acc + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
    if (w > W_MAX) w = W_MAX;
    if (w < W_MIN) w = W_MIN;
    ff_acc += longint'(ff_coef[0]) * w;
    y = (ff_acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    for (int k = ORDER - 1; k >= 1; k--) begin
      delay_w[k] = delay_w[k-1];
    end
    delay_w[0] = dly_t'(w);
    return sample_t'(y);
  endfunction

  function automatic coef_t pick_coef(input coef_mode_t mode, input int idx);
    coef_t c;
    case (mode)
      COEF_MILD: begin
        // Feedback taps small enough that the recursion stays stable.
        if (idx < REG_FB_FIRST) c = coef_t'(int'($urandom_range(32768)) - 16384);
        else c = coef_t'(int'($urandom_range(10000)) - 5000);
      end
      COEF_EXTREME: begin
        c = ($urandom_range(1) != 0) ? COEF_MAX : COEF_MIN;
      end
      default: begin
        c = coef_t'($urandom);
      end
    endcase
    return c;
  endfunction

  function automatic sample_t pick_sample(input samp_mode_t mode);
    sample_t s;
    case (mode)
      SAMP_SMALL: begin
        s = sample_t'(int'($urandom_range(2000)) - 1000);
      end
      SAMP_EDGE: begin
        case ($urandom_range(4))
          0: s = sample_t'(32767);
          1: s = sample_t'(-32768);
          2: s = sample_t'(1);
          3: s = sample_t'(-1);
          default: s = '0;
        endcase
      end
      default: begin
        s = sample_t'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic add_sample(input sample_t s);
    pending_samples.push_back(s);
    queued_count++;
  endtask

  // Register write: enable for one cycle, then low again before the next write.
  task automatic write_reg(input cfg_idx_t idx, input coef_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    write_coef_model(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_coefs(input coef_mode_t mode);
    for (int r = 0; r < NUM_REGS; r++) begin
      write_reg(cfg_idx_t'(r), pick_coef(mode, r));
    end
  endtask

  // Hold the sender until every queued sample is through, then let the
  // pipeline settle before anything is reconfigured.
  task automatic drain();
    while (accepted_count != queued_count || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: hold a stalled transfer, otherwise offer the next sample
  // unless this cycle idles.
  always @(negedge clk) begin : drive_proc
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid     <= 1'b1;
        in_sample_in <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall, random except in the calm stretch.
  always @(negedge clk) begin : stall_proc
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin : check_proc
    sample_t want;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_samples.push_back(filter_step(in_sample_in));
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output %0d with no sample pending", out_sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            report_mismatch($sformatf("sample_out got %0d, want %0d", out_sample_out, want));
          end
        end
      end
    end
  end

  initial begin : stim_proc
    coef_mode_t mode;
    int         roll;
    reset_filter_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset coefficients pass the sample straight through.
    add_sample(sample_t'(0));
    add_sample(sample_t'(32767));
    add_sample(sample_t'(-32768));
    add_sample(sample_t'(1));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(16'h5555));
    add_sample(sample_t'(16'hAAAA));
    add_sample(sample_t'(0));
    drain();

    // Opposed extremes drive w into saturation; the unused index is ignored.
    write_reg(cfg_idx_t'(REG_FF0), COEF_MAX);
    for (int k = 1; k <= NUM_COEF_TAPS; k++) begin
      write_reg(cfg_idx_t'(REG_FF0 + k), COEF_MIN);
      write_reg(cfg_idx_t'(REG_FB_FIRST + k - 1), COEF_MAX);
    end
    write_reg(REG_UNUSED, '0);
    for (int n = 0; n < 3; n++) add_sample(sample_t'(32767));
    for (int n = 0; n < 3; n++) add_sample(sample_t'(-32768));
    add_sample(sample_t'(0));
    add_sample(sample_t'(1));
    drain();

    // Every coefficient at its negative extreme.
    for (int r = 0; r < NUM_REGS; r++) begin
      write_reg(cfg_idx_t'(r), COEF_MIN);
    end
    write_reg(REG_UNUSED, COEF_MAX);
    for (int n = 0; n < 4; n++) begin
      add_sample(sample_t'(32767));
      add_sample(sample_t'(-32768));
    end
    drain();

    // Random phases, each with its own coefficient set.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0, 2:    mode = COEF_MILD;
        1:       mode = COEF_FULL;
        default: mode = COEF_EXTREME;
      endcase
      if (p == CALM_PHASE) mode = COEF_MILD;
      load_coefs(mode);
      write_reg(REG_UNUSED, coef_t'($urandom));
      calm = (p == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 60) add_sample(pick_sample(SAMP_FULL));
        else if (roll < 90) add_sample(pick_sample(SAMP_SMALL));
        else add_sample(pick_sample(SAMP_EDGE));
      end
      drain();
      calm = 1'b0;
    end

    if (error_count == 0) begin
      $display("tb_iir_direct_form_two_top passed");
    end else begin
      $display("tb_iir_direct_form_two_top failed");
    end
    $finish;
  end

  // Watchdog for a filter that stops taking or producing samples.
  initial begin : watchdog_proc
    #TIMEOUT_NS;
    $display("tb_iir_direct_form_two_top failed");
    $finish;
  end

endmodule

@@ iir_direct_form_two_top.f @@
src/iirdf2_pkg.sv
src/iirdf2_cell.sv
src/iirdf2_mac.sv
src/iir_direct_form_two_top.sv
tb/tb_iir_direct_form_two_top.sv
